// ===== src/acfp_pkg.sv =====
package acfp_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ID   = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_TERM = 3'd4
    } t_phase;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADHEX  = 3'd1;
    localparam logic [2:0] ST_BADLEN  = 3'd2;
    localparam logic [2:0] ST_BADTERM = 3'd3;
    localparam logic [2:0] ST_RESTART = 3'd4;

    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;

    localparam int IdDigits = 3;

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h10;
        if (c >= CH_0 && c <= CH_9) begin
            v = c - CH_0;
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = c - CH_UP_A + 8'd10;
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            v = c - CH_LO_A + 8'd10;
        end
        return v[4:0];
    endfunction

endpackage

// ===== src/acfp_parse.sv =====
module acfp_parse #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_byte,
    input  logic        i_out_stall,
    output logic        o_advance,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [11:0] o_can_id,
    output logic [3:0]  o_data_length,
    output logic [63:0] o_frame_data
);
    import acfp_pkg::*;

    localparam int DataW = 8 * MAX_DATA_BYTES;
    localparam int NibN  = 2 * MAX_DATA_BYTES;
    localparam int CntW  = $clog2(NibN + 1);

    t_phase            r_phase, n_phase;
    logic [CntW-1:0]   r_count, n_count;
    logic [11:0]       r_id, n_id;
    logic [3:0]        r_len, n_len;
    logic [DataW-1:0]  r_data, n_data;

    logic              r_out_valid;
    logic [2:0]        r_status;
    logic [11:0]       r_out_id;
    logic [3:0]        r_out_len;
    logic [63:0]       r_out_data;

    logic              n_emit;
    logic [2:0]        n_status;
    logic [4:0]        w_nib;
    logic              w_is_cr;
    logic              w_is_t;
    logic              w_fire;

    assign o_advance = !r_out_valid || !i_out_stall;
    assign w_fire    = i_valid && o_advance;
    assign w_nib     = hex_value(i_byte);
    assign w_is_cr   = (i_byte == CH_CR) || (i_byte == CH_NUL);
    assign w_is_t    = (i_byte == CH_T);

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_id     = r_id;
        n_len    = r_len;
        n_data   = r_data;
        n_emit   = 1'b0;
        n_status = ST_OK;

        if (r_phase == PH_HUNT) begin
            if (w_is_t) begin
                n_phase = PH_ID;
                n_count = '0;
                n_id    = '0;
                n_len   = '0;
                n_data  = '0;
            end
        end else if (w_is_t) begin
            n_emit   = 1'b1;
            n_status = ST_RESTART;
            n_phase  = PH_ID;
            n_count  = '0;
            n_id     = '0;
            n_len    = '0;
            n_data   = '0;
        end else if (r_phase == PH_TERM) begin
            n_emit   = 1'b1;
            n_status = w_is_cr ? ST_OK : ST_BADTERM;
            n_phase  = PH_HUNT;
            n_count  = '0;
        end else if (w_is_cr) begin
            n_emit   = 1'b1;
            n_status = ST_BADTERM;
            n_phase  = PH_HUNT;
            n_count  = '0;
        end else if (w_nib[4]) begin
            n_emit   = 1'b1;
            n_status = ST_BADHEX;
            n_phase  = PH_HUNT;
            n_count  = '0;
        end else begin
            unique case (r_phase)
                PH_ID: begin
                    n_id = {r_id[7:0], w_nib[3:0]};
                    if (r_count == CntW'(IdDigits - 1)) begin
                        n_phase = PH_LEN;
                        n_count = '0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                PH_LEN: begin
                    if (w_nib > 5'(MAX_DATA_BYTES)) begin
                        n_emit   = 1'b1;
                        n_status = ST_BADLEN;
                        n_phase  = PH_HUNT;
                        n_count  = '0;
                    end else begin
                        n_len   = w_nib[3:0];
                        n_count = '0;
                        n_phase = (w_nib == 5'd0) ? PH_TERM : PH_DATA;
                    end
                end
                default: begin
                    // The high nibble of each byte arrives first.
                    for (int i = 0; i < NibN; i++) begin
                        if (r_count == CntW'(i ^ 1)) begin
                            n_data[4*i +: 4] = r_data[4*i +: 4] | w_nib[3:0];
                        end
                    end
                    if (r_count == CntW'({r_len, 1'b0} - 5'd1)) begin
                        n_phase = PH_TERM;
                        n_count = '0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_count     <= '0;
            r_id        <= '0;
            r_len       <= '0;
            r_data      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_id    <= n_id;
                r_len   <= n_len;
                r_data  <= n_data;
            end
            if (o_advance) begin
                r_out_valid <= w_fire && n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_emit) begin
            r_status   <= n_status;
            r_out_id   <= (n_status == ST_OK) ? r_id : 12'd0;
            r_out_len  <= (n_status == ST_OK) ? r_len : 4'd0;
            r_out_data <= (n_status == ST_OK) ? 64'(r_data) : 64'd0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_can_id      = r_out_id;
    assign o_data_length = r_out_len;
    assign o_frame_data  = r_out_data;

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status != ST_OK |->
            r_out_id == 12'd0 && r_out_len == 4'd0 && r_out_data == 64'd0)
        else $error("Error transaction carries non-zero fields.");

    a_ok_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_OK |-> r_out_len <= 4'(MAX_DATA_BYTES))
        else $error("Good frame reports a length above the maximum.");

    a_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && n_emit && n_status != ST_RESTART |=> r_phase == PH_HUNT)
        else $error("Parser did not return to hunting after a result.");

    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_len != 4'd0)
        else $error("Data digits expected with a zero length.");

endmodule

// ===== src/ascii_can_frame_parser.sv =====
// Parses ASCII standard CAN data frames ('t', three hex identifier digits, one length
// digit, two hex digits per data byte, then carriage return or a zero byte) from a
// stream of received bytes, one byte per transaction. A byte is taken every cycle
// while the result side keeps up; each byte passes an input register and then a
// result register, which takes the result for the byte that completes or breaks
// the frame. Only the result register stalling the input slows it down.
module ascii_can_frame_parser #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [2:0]  o_status,
    output logic [11:0] o_can_id,
    output logic [3:0]  o_data_length,
    output logic [63:0] o_frame_data
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_advance;

    assign o_rx_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_rx_stall) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && !o_rx_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    acfp_parse #(
        .MAX_DATA_BYTES(MAX_DATA_BYTES)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_byte       (r_in_byte),
        .i_out_stall  (i_res_stall),
        .o_advance    (w_advance),
        .o_valid      (o_res_valid),
        .o_status     (o_status),
        .o_can_id     (o_can_id),
        .o_data_length(o_data_length),
        .o_frame_data (o_frame_data)
    );

endmodule
